/* rtl/bpd_pkg.sv */
package bpd_pkg;

  localparam int CordicSteps = 16;
  localparam int FullCmd     = 65536;
  localparam int PiQ13       = 25736;
  localparam int TwoPiQ13    = 51472;
  localparam int PiQ16       = 205887;
  localparam int QueueDepth  = 4;
  localparam int QueueAw     = 2;

  // CORDIC datapath width: 16-bit input times 256, plus gain growth
  localparam int CordW = 28;
  localparam int ZW    = 20;

  typedef enum logic [2:0] {
    REG_STAB    = 3'd0,
    REG_MAXP    = 3'd1,
    REG_FSHARE  = 3'd2,
    REG_EFLOOR  = 3'd3,
    REG_DLIMIT  = 3'd4,
    REG_SGAIN   = 3'd5,
    REG_RBAL    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        stability_enable;
    logic [21:0] max_pressure;
    logic [16:0] front_share;
    logic [21:0] ebrake_floor;
    logic [14:0] drift_limit;
    logic [15:0] side_gain;
    logic [15:0] rear_balance;
  } cfg_t;

  // one classified item as it leaves the front part
  typedef struct packed {
    logic [16:0] total;
    logic [16:0] fr;
    logic [16:0] fl;
    logic [16:0] rr;
    logic [16:0] rl;
    logic        per_wheel;
    logic        ebrake;
    logic        stab;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] heading;
  } item_t;

  function automatic logic [19:0] atan_entry(input int i);
    logic [19:0] r;
    unique case (i)
      0: r = 20'd51472;  1: r = 20'd30386;  2: r = 20'd16055;  3: r = 20'd8150;
      4: r = 20'd4091;   5: r = 20'd2047;   6: r = 20'd1024;   7: r = 20'd512;
      8: r = 20'd256;    9: r = 20'd128;    10: r = 20'd64;    11: r = 20'd32;
      12: r = 20'd16;    13: r = 20'd8;     14: r = 20'd4;     15: r = 20'd2;
      16: r = 20'd1;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] sat_cmd(input logic [16:0] v);
    return (v > 17'(FullCmd)) ? 17'(FullCmd) : v;
  endfunction

endpackage

/* rtl/bpd_front.sv */
module bpd_front import bpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [16:0] total_cmd,
  input  logic [16:0] front_right_cmd,
  input  logic [16:0] front_left_cmd,
  input  logic [16:0] rear_right_cmd,
  input  logic [16:0] rear_left_cmd,
  input  logic        per_wheel_mode,
  input  logic        ebrake_on,
  input  logic [15:0] velocity_x,
  input  logic [15:0] velocity_y,
  input  logic [15:0] heading,
  input  logic        stab_en,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t              mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0]   count;
  logic               push;
  item_t              in_item;

  // saturate commands and tag the item on entry
  always_comb begin
    in_item.total     = sat_cmd(total_cmd);
    in_item.fr        = sat_cmd(front_right_cmd);
    in_item.fl        = sat_cmd(front_left_cmd);
    in_item.rr        = sat_cmd(rear_right_cmd);
    in_item.rl        = sat_cmd(rear_left_cmd);
    in_item.per_wheel = per_wheel_mode;
    in_item.ebrake    = ebrake_on;
    in_item.stab      = stab_en;
    in_item.vx        = velocity_x;
    in_item.vy        = velocity_y;
    in_item.heading   = heading;
  end

  assign in_stall = (count == (QueueAw+1)'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueueAw+1)'(push) - (QueueAw+1)'(q_pop);
    end
  end

endmodule

/* rtl/bpd_back.sv */
module bpd_back import bpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] pressure_fr,
  output logic [21:0] pressure_fl,
  output logic [21:0] pressure_rr,
  output logic [21:0] pressure_rl,
  output logic        correction_active
);

  localparam int NS = CordicSteps + 5;  // index of the last stage in the pipe

  // per-stage valid and sideband
  logic        v [NS+1];
  item_t       it [NS+1];
  logic signed [CordW-1:0] cx [CordicSteps+1];
  logic signed [CordW-1:0] cy [CordicSteps+1];
  logic signed [ZW-1:0]    cz [CordicSteps+1];

  logic adv;
  assign adv   = !(v[NS] && out_stall);
  assign q_pop = q_valid && adv;

  // stage 0: pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (adv) v[0] <= q_valid;
  end

  always_ff @(posedge clk) begin
    logic signed [CordW-1:0] x0;
    logic signed [CordW-1:0] y0;
    x0 = {{(CordW-24){q_item.vx[15]}}, q_item.vx, 8'd0};
    y0 = {{(CordW-24){q_item.vy[15]}}, q_item.vy, 8'd0};
    if (adv) begin
      it[0] <= q_item;
      if (x0 < 0) begin
        cx[0] <= -x0;
        cy[0] <= -y0;
        cz[0] <= (y0 >= 0) ? ZW'(PiQ16) : -ZW'(PiQ16);
      end else begin
        cx[0] <= x0;
        cy[0] <= y0;
        cz[0] <= '0;
      end
    end
  end

  // CORDIC vectoring stages
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cord
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (adv) v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        it[i+1] <= it[i];
        if (cy[i] >= 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ZW'(atan_entry(i));
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ZW'(atan_entry(i));
        end
      end
    end
  end

  // stage A: drift angle, wrap, magnitude
  localparam int SA = CordicSteps;
  logic signed [17:0] drift_a;
  logic               act_a;
  always_ff @(posedge clk) begin
    logic signed [ZW-1:0] zr;
    logic signed [17:0]   ang;
    logic signed [17:0]   d;
    logic        [17:0]   mag;
    zr  = (cz[SA] + ZW'(4)) >>> 3;
    ang = ((it[SA].vx == 16'd0) && (it[SA].vy == 16'd0)) ? 18'sd0 : 18'(zr);
    d   = ang - 18'($signed(it[SA].heading));
    if (d > 18'sd25736) d = d - 18'(TwoPiQ13);
    else if (d < -18'sd25736) d = d + 18'(TwoPiQ13);
    mag = d[17] ? 18'(-d) : 18'(d);
    if (rst) v[SA+1] <= 1'b0;
    else if (adv) v[SA+1] <= v[SA];
    if (adv) begin
      it[SA+1] <= it[SA];
      drift_a  <= d;
      act_a    <= it[SA].stab && (mag > {3'd0, cfg.drift_limit});
    end
  end

  // stage B: side term
  logic signed [18:0] side_b;
  logic               act_b;
  always_ff @(posedge clk) begin
    logic signed [34:0] prod;
    prod = $signed({1'b0, cfg.side_gain}) * drift_a + 35'sd4096;
    if (rst) v[SA+2] <= 1'b0;
    else if (adv) v[SA+2] <= v[SA+1];
    if (adv) begin
      it[SA+2] <= it[SA+1];
      side_b   <= 19'(prod >>> 13);
      act_b    <= act_a;
    end
  end

  function automatic logic [16:0] clampc(input logic signed [19:0] x);
    if (x < 0) return 17'd0;
    if (x > 20'sd65536) return 17'(FullCmd);
    return x[16:0];
  endfunction

  // stage C: pick command and share per wheel
  logic [16:0] cmd_c [4];
  logic [16:0] shr_c [4];
  logic        split_c, act_c;
  always_ff @(posedge clk) begin
    logic signed [19:0] s, b, t;
    logic [16:0] fsh;
    s   = 20'(side_b);
    b   = $signed({4'd0, cfg.rear_balance});
    t   = $signed({3'd0, it[SA+2].total});
    fsh = (cfg.front_share > 17'(FullCmd)) ? 17'(FullCmd) : cfg.front_share;
    if (rst) v[SA+3] <= 1'b0;
    else if (adv) v[SA+3] <= v[SA+2];
    if (adv) begin
      it[SA+3] <= it[SA+2];
      act_c    <= act_b;
      shr_c[0] <= fsh; shr_c[1] <= fsh;
      shr_c[2] <= 17'(FullCmd) - fsh; shr_c[3] <= 17'(FullCmd) - fsh;
      split_c  <= !it[SA+2].per_wheel;
      if (it[SA+2].per_wheel) begin
        if (act_b) begin
          cmd_c[0] <= clampc($signed({3'd0, it[SA+2].fr}) - s);
          cmd_c[1] <= clampc($signed({3'd0, it[SA+2].fl}) + s);
          cmd_c[2] <= clampc($signed({3'd0, it[SA+2].rr}) - b - s);
          cmd_c[3] <= clampc($signed({3'd0, it[SA+2].rl}) - b + s);
        end else begin
          cmd_c[0] <= it[SA+2].fr; cmd_c[1] <= it[SA+2].fl;
          cmd_c[2] <= it[SA+2].rr; cmd_c[3] <= it[SA+2].rl;
        end
      end else if (act_b) begin
        cmd_c[0] <= clampc(t - s);
        cmd_c[1] <= clampc(t + s);
        cmd_c[2] <= clampc(t - s - b);
        cmd_c[3] <= clampc(t + s - b);
      end else begin
        for (int k = 0; k < 4; k++) cmd_c[k] <= it[SA+2].total;
      end
    end
  end

  // stage D: command times max pressure
  logic [38:0] cp_d [4];
  logic [16:0] shr_d [4];
  logic        split_d, act_d;
  always_ff @(posedge clk) begin
    if (rst) v[SA+4] <= 1'b0;
    else if (adv) v[SA+4] <= v[SA+3];
    if (adv) begin
      it[SA+4] <= it[SA+3];
      split_d  <= split_c;
      act_d    <= act_c;
      for (int k = 0; k < 4; k++) begin
        cp_d[k]  <= 39'(cmd_c[k]) * 39'(cfg.max_pressure);
        shr_d[k] <= shr_c[k];
      end
    end
  end

  // stage E: share (split) or rounding (per wheel), e-brake floor
  always_ff @(posedge clk) begin
    logic [55:0] sp;
    logic [21:0] p [4];
    for (int k = 0; k < 4; k++) begin
      sp   = 56'(cp_d[k]) * 56'(shr_d[k]) + 56'h80000000;
      p[k] = split_d ? sp[53:32] : 22'((cp_d[k] + 39'd32768) >> 16);
    end
    if (it[SA+4].ebrake && (p[2] < cfg.ebrake_floor)) begin
      p[2] = cfg.ebrake_floor;
      p[3] = cfg.ebrake_floor;
    end
    if (rst) v[NS] <= 1'b0;
    else if (adv) v[NS] <= v[SA+4];
    if (adv) begin
      pressure_fr       <= p[0];
      pressure_fl       <= p[1];
      pressure_rr       <= p[2];
      pressure_rl       <= p[3];
      correction_active <= act_d;
    end
  end

  assign out_valid = v[NS];

endmodule

/* rtl/brake_pressure_distribution.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | commands, modes, velocities, heading
// out     | output    | out_valid/out_stall| four pressures, correction_active
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each item goes through
// the queue, the pre-rotation stage, the pipelined CORDIC and the five stages
// behind it. A four-entry queue separates input from the pipe.
// Synchronous reset restores register defaults and empties queue and pipe.
// A held out_stall freezes the pipe while a result waits; the queue then fills and raises in_stall.
module brake_pressure_distribution import bpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [16:0] total_cmd,
  input  logic [16:0] front_right_cmd,
  input  logic [16:0] front_left_cmd,
  input  logic [16:0] rear_right_cmd,
  input  logic [16:0] rear_left_cmd,
  input  logic        per_wheel_mode,
  input  logic        ebrake_on,
  input  logic [15:0] velocity_x,
  input  logic [15:0] velocity_y,
  input  logic [15:0] heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] pressure_fr,
  output logic [21:0] pressure_fl,
  output logic [21:0] pressure_rr,
  output logic [21:0] pressure_rl,
  output logic        correction_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg;
  logic  q_valid, q_pop;
  item_t q_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stability_enable <= 1'b0;
      cfg.max_pressure     <= 22'd1000000;
      cfg.front_share      <= 17'd32768;
      cfg.ebrake_floor     <= 22'd0;
      cfg.drift_limit      <= 15'd1072;
      cfg.side_gain        <= 16'd1252;
      cfg.rear_balance     <= 16'd328;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STAB:   cfg.stability_enable <= cfg_data[0];
        REG_MAXP:   cfg.max_pressure     <= cfg_data[21:0];
        REG_FSHARE: cfg.front_share      <= cfg_data[16:0];
        REG_EFLOOR: cfg.ebrake_floor     <= cfg_data[21:0];
        REG_DLIMIT: cfg.drift_limit      <= cfg_data[14:0];
        REG_SGAIN:  cfg.side_gain        <= cfg_data[15:0];
        REG_RBAL:   cfg.rear_balance     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bpd_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .total_cmd, .front_right_cmd, .front_left_cmd, .rear_right_cmd,
    .rear_left_cmd, .per_wheel_mode, .ebrake_on, .velocity_x, .velocity_y,
    .heading, .stab_en(cfg.stability_enable),
    .q_valid, .q_item, .q_pop
  );

  bpd_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall,
    .pressure_fr, .pressure_fl, .pressure_rr, .pressure_rl, .correction_active
  );

endmodule

/* rtl/bpd_checker.sv */
module bpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [21:0] pressure_fr,
  input logic        correction_active,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressure_fr) &&
    $stable(correction_active))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input item dropped");

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind brake_pressure_distribution bpd_checker u_bpd_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .pressure_fr, .correction_active, .cfg_ready
);
